// File: rtl/rpms_pkg.sv
// Package with the shared types, constants and codes of the maze step block.
package rpms_pkg;

    localparam int MaxSide    = 64;
    localparam int CoordW     = $clog2(MaxSide);
    localparam int CellTotal  = MaxSide * MaxSide;
    localparam int IdW        = $clog2(CellTotal);
    localparam int CountW     = IdW + 1;
    localparam int SideW      = 7;
    localparam int PickW      = 32;

    localparam logic [1:0] StRestart = 2'd0;
    localparam logic [1:0] StAdded   = 2'd1;
    localparam logic [1:0] StEmpty   = 2'd2;

    localparam logic [2:0] DirRight = 3'd0;
    localparam logic [2:0] DirLeft  = 3'd1;
    localparam logic [2:0] DirDown  = 3'd2;
    localparam logic [2:0] DirUp    = 3'd3;
    localparam logic [2:0] DirNone  = 3'd4;

    localparam logic [1:0] MarkFree  = 2'd0;
    localparam logic [1:0] MarkMaze  = 2'd1;
    localparam logic [1:0] MarkFront = 2'd2;

    typedef enum logic [4:0] {
        S_CLEAR,     // clearing pass over the cell marks
        S_IDLE,
        S_RST_INIT,  // restart: clear marks again
        S_RST_SEED,  // mark start cell and the two seed cells
        S_MOD,       // pick modulo count, one bit per cycle
        S_RDID,      // read the chosen frontier entry
        S_WTID,
        S_MARK,      // mark chosen cell in maze
        S_NB_RD,     // read a neighbour mark
        S_NB_WT,
        S_NB_DO,     // append it when free
        S_WL_RD,     // wall search read
        S_WL_WT,
        S_WL_DO,
        S_SH_RD,     // shift the frontier list down one entry
        S_SH_WT,
        S_SH_WR,
        S_OUT
    } t_state;

    typedef struct packed {
        logic clr_start;   // start the clearing sweep
        logic clr_step;
        logic seed;
        logic mod_start;
        logic mod_step;
        logic id_read;
        logic mark_cur;
        logic nb_do;
        logic wl_read;
        logic wl_do;
        logic sh_read;
        logic sh_write;
        logic load_out;
        logic load_empty;
        logic load_restart;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic mod_done;
        logic nb_last;
        logic wl_last;
        logic sh_done;
        logic count_zero;
    } t_status;

endpackage

// File: rtl/rpms_if.sv
// Valid/ready channel interfaces for items, results and configuration.
interface rpms_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [31:0] pick_random;
    logic [7:0] dir_order;
    modport source (output valid, mode, pick_random, dir_order, input ready);
    modport sink (input valid, mode, pick_random, dir_order, output ready);
endinterface

interface rpms_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [5:0]  cell_x;
    logic [5:0]  cell_y;
    logic [2:0]  wall_dir;
    logic [12:0] frontier_left;
    logic        done_res;
    modport source (output valid, status, cell_x, cell_y, wall_dir, frontier_left,
                    done_res, input ready);
    modport sink (input valid, status, cell_x, cell_y, wall_dir, frontier_left,
                  done_res, output ready);
endinterface

interface rpms_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] grid_side;
    modport source (output valid, grid_side, input ready);
    modport sink (input valid, grid_side, output ready);
endinterface

// File: rtl/rpms_ram.sv
// Generic single-port-write, one-read-port RAM with registered read data.
module rpms_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: rtl/rpms_datapath.sv
// Datapath: cell mark and frontier memories, modulo unit, neighbour and wall logic.
module rpms_datapath (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  rpms_pkg::t_cmd          i_cmd,
    output rpms_pkg::t_status       o_sts,
    input  logic [6:0]              i_side_cfg,
    input  logic [31:0]             i_pick,
    input  logic [7:0]              i_order,
    output logic [1:0]              o_status,
    output logic [5:0]              o_cell_x,
    output logic [5:0]              o_cell_y,
    output logic [2:0]              o_wall_dir,
    output logic [12:0]             o_frontier_left,
    output logic                    o_done_res
);
    localparam int IdW = rpms_pkg::IdW;
    localparam int CW  = rpms_pkg::CoordW;
    localparam int NW  = rpms_pkg::CountW;

    // Mark memory.
    logic          m_we;
    logic [IdW-1:0] m_waddr, m_raddr;
    logic [1:0]    m_wdata, m_rdata;
    // Frontier memory.
    logic          f_we;
    logic [IdW-1:0] f_waddr, f_raddr;
    logic [IdW-1:0] f_wdata, f_rdata;

    rpms_ram #(.Width(2), .Depth(rpms_pkg::CellTotal)) u_marks (
        .i_clk, .i_we(m_we), .i_waddr(m_waddr), .i_wdata(m_wdata),
        .i_raddr(m_raddr), .o_rdata(m_rdata));
    rpms_ram #(.Width(IdW), .Depth(rpms_pkg::CellTotal)) u_front (
        .i_clk, .i_we(f_we), .i_waddr(f_waddr), .i_wdata(f_wdata),
        .i_raddr(f_raddr), .o_rdata(f_rdata));

    logic [NW-1:0]  r_count, n_count;
    logic [6:0]     r_side, n_side;
    logic [IdW-1:0] r_clr;
    logic [NW-1:0]  r_rem;
    logic [31:0]    r_quo;
    logic [5:0]     r_bit;
    logic [IdW-1:0] r_idx;
    logic [CW-1:0]  r_x, r_y;
    logic [1:0]     r_nb;
    logic [1:0]     r_wl;
    logic [2:0]     r_wall;
    logic           r_found;
    logic [1:0]     r_seed;

    // The chosen entry is on the frontier read port during S_MARK.
    logic [CW-1:0] w_x, w_y;
    assign w_x = f_rdata[CW-1:0];
    assign w_y = f_rdata[IdW-1:CW];

    // Remainder step of the restoring modulo.
    logic [NW:0] w_trial;
    assign w_trial = {r_rem, r_quo[31]} - {1'b0, r_count};

    // Neighbour in a given direction: existence and address.
    function automatic logic [IdW:0] nb_addr(input logic [CW-1:0] x, input logic [CW-1:0] y,
                                             input logic [1:0] d, input logic [6:0] s);
        logic [7:0] xs, ys;
        logic       ok;
        logic [CW-1:0] nx, ny;
        xs = {2'b0, x} + 8'd1;
        ys = {2'b0, y} + 8'd1;
        nx = x;
        ny = y;
        ok = 1'b0;
        case (d)
            2'd0: begin ok = xs < {1'b0, s}; nx = x + 1'b1; end
            2'd1: begin ok = x != '0; nx = x - 1'b1; end
            2'd2: begin ok = ys < {1'b0, s}; ny = y + 1'b1; end
            default: begin ok = y != '0; ny = y - 1'b1; end
        endcase
        return {ok, ny, nx};
    endfunction

    logic [IdW:0] w_nb, w_wl;
    logic [1:0]   w_wd;
    assign w_nb = nb_addr(r_x, r_y, r_nb, r_side);
    assign w_wd = i_order[2*r_wl +: 2];
    assign w_wl = nb_addr(r_x, r_y, w_wd, r_side);

    always_comb begin
        m_we    = 1'b0;
        m_waddr = r_clr;
        m_wdata = rpms_pkg::MarkFree;
        m_raddr = w_nb[IdW-1:0];
        f_we    = 1'b0;
        f_waddr = r_count[IdW-1:0];
        f_wdata = w_nb[IdW-1:0];
        f_raddr = r_idx;
        if (i_cmd.clr_step) begin
            m_we = 1'b1;
        end
        if (i_cmd.seed) begin
            m_we = 1'b1;
            case (r_seed)
                2'd0: begin m_waddr = '0; m_wdata = rpms_pkg::MarkMaze; end
                2'd1: begin
                    m_waddr = IdW'(1); m_wdata = rpms_pkg::MarkFront;
                    f_we = 1'b1; f_waddr = '0; f_wdata = IdW'(1);
                end
                default: begin
                    m_waddr = IdW'(rpms_pkg::MaxSide); m_wdata = rpms_pkg::MarkFront;
                    f_we = 1'b1; f_waddr = IdW'(1); f_wdata = IdW'(rpms_pkg::MaxSide);
                end
            endcase
        end
        if (i_cmd.mark_cur) begin
            m_we = 1'b1;
            m_waddr = {w_y, w_x};
            m_wdata = rpms_pkg::MarkMaze;
        end
        if (i_cmd.nb_do && w_nb[IdW] && m_rdata == rpms_pkg::MarkFree) begin
            m_we = 1'b1;
            m_waddr = w_nb[IdW-1:0];
            m_wdata = rpms_pkg::MarkFront;
            f_we = 1'b1;
        end
        if (i_cmd.wl_read) begin
            m_raddr = w_wl[IdW-1:0];
        end
        if (i_cmd.sh_read) begin
            f_raddr = r_idx + 1'b1;
        end
        if (i_cmd.sh_write) begin
            f_we = 1'b1;
            f_waddr = r_idx;
            f_wdata = f_rdata;
        end
    end

    always_comb begin
        n_count = r_count;
        n_side  = r_side;
        if (i_cmd.load_restart) begin
            n_count = NW'(2);
            if (i_side_cfg < 7'd2) begin
                n_side = 7'd2;
            end else if (i_side_cfg > 7'(rpms_pkg::MaxSide)) begin
                n_side = 7'(rpms_pkg::MaxSide);
            end else begin
                n_side = i_side_cfg;
            end
        end
        if (i_cmd.nb_do && w_nb[IdW] && m_rdata == rpms_pkg::MarkFree) begin
            n_count = r_count + 1'b1;
        end
        if (i_cmd.load_out) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_side  <= 7'(rpms_pkg::MaxSide);
            r_clr   <= '0;
            r_seed  <= '0;
        end else begin
            r_count <= n_count;
            r_side  <= n_side;
            if (i_cmd.clr_start) begin
                r_clr <= '0;
                r_seed <= '0;
            end else if (i_cmd.clr_step) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.seed) begin
                r_seed <= r_seed + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mod_start) begin
            r_rem <= '0;
            r_quo <= i_pick;
            r_bit <= '0;
        end else if (i_cmd.mod_step) begin
            r_quo <= {r_quo[30:0], 1'b0};
            r_bit <= r_bit + 1'b1;
            if (!w_trial[NW]) begin
                r_rem <= w_trial[NW-1:0];
            end else begin
                r_rem <= {r_rem[NW-2:0], r_quo[31]};
            end
        end
        if (i_cmd.id_read) begin
            r_idx <= r_rem[IdW-1:0];
        end
        if (i_cmd.mark_cur) begin
            r_x  <= w_x;
            r_y  <= w_y;
            r_nb <= '0;
            r_wl <= '0;
            r_found <= 1'b0;
            r_wall <= rpms_pkg::DirNone;
        end
        if (i_cmd.nb_do) begin
            r_nb <= r_nb + 1'b1;
        end
        if (i_cmd.wl_do) begin
            r_wl <= r_wl + 1'b1;
            if (!r_found && w_wl[IdW] && m_rdata == rpms_pkg::MarkMaze) begin
                r_found <= 1'b1;
                r_wall <= {1'b0, w_wd};
            end
        end
        if (i_cmd.sh_write) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_status <= rpms_pkg::StEmpty;
        end else if (i_cmd.load_restart) begin
            o_status <= rpms_pkg::StRestart;
            o_cell_x <= '0;
            o_cell_y <= '0;
            o_wall_dir <= rpms_pkg::DirNone;
            o_frontier_left <= 13'd2;
            o_done_res <= 1'b0;
        end else if (i_cmd.load_empty) begin
            o_status <= rpms_pkg::StEmpty;
            o_cell_x <= '0;
            o_cell_y <= '0;
            o_wall_dir <= rpms_pkg::DirNone;
            o_frontier_left <= '0;
            o_done_res <= 1'b1;
        end else if (i_cmd.load_out) begin
            o_status <= rpms_pkg::StAdded;
            o_cell_x <= 6'(r_x);
            o_cell_y <= 6'(r_y);
            o_wall_dir <= r_wall;
            o_frontier_left <= 13'(r_count - 1'b1);
            o_done_res <= r_count == NW'(1);
        end
    end

    assign o_sts.clr_done   = &r_clr;
    assign o_sts.mod_done   = &r_bit[4:0];
    assign o_sts.nb_last    = &r_nb;
    assign o_sts.wl_last    = &r_wl;
    assign o_sts.sh_done    = {1'b0, r_idx} + 1'b1 >= r_count;
    assign o_sts.count_zero = r_count == '0;

    logic w_unused;
    assign w_unused = r_bit[5];
endmodule

// File: rtl/rpms_ctrl.sv
// Controller state machine sequencing restart and expansion steps.
module rpms_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_mode,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output rpms_pkg::t_cmd    o_cmd,
    input  rpms_pkg::t_status i_sts
);
    rpms_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;
    logic             w_take, w_load;

    // Seed writes are counted here.
    logic [1:0] r_seed_cnt;
    logic       r_seed_last;
    assign r_seed_last = r_seed_cnt == 2'd2;

    assign o_out_valid = r_out_valid;
    assign o_in_ready  = (r_state == rpms_pkg::S_IDLE) && !r_out_valid;
    assign w_take      = i_in_valid && o_in_ready;
    assign w_load      = o_cmd.load_out || o_cmd.load_empty || o_cmd.load_restart;

    always_comb begin
        n_state = r_state;
        case (r_state)
            rpms_pkg::S_CLEAR:    if (i_sts.clr_done) n_state = rpms_pkg::S_IDLE;
            rpms_pkg::S_IDLE: begin
                if (w_take) begin
                    if (!i_mode) n_state = rpms_pkg::S_RST_INIT;
                    else if (i_sts.count_zero) n_state = rpms_pkg::S_IDLE;
                    else n_state = rpms_pkg::S_MOD;
                end
            end
            rpms_pkg::S_RST_INIT: if (i_sts.clr_done) n_state = rpms_pkg::S_RST_SEED;
            rpms_pkg::S_RST_SEED: n_state = rpms_pkg::S_RST_SEED;
            rpms_pkg::S_MOD:      if (i_sts.mod_done) n_state = rpms_pkg::S_RDID;
            rpms_pkg::S_RDID:     n_state = rpms_pkg::S_WTID;
            rpms_pkg::S_WTID:     n_state = rpms_pkg::S_MARK;
            rpms_pkg::S_MARK:     n_state = rpms_pkg::S_NB_RD;
            rpms_pkg::S_NB_RD:    n_state = rpms_pkg::S_NB_WT;
            rpms_pkg::S_NB_WT:    n_state = rpms_pkg::S_NB_DO;
            rpms_pkg::S_NB_DO:    n_state = i_sts.nb_last ? rpms_pkg::S_WL_RD
                                                          : rpms_pkg::S_NB_RD;
            rpms_pkg::S_WL_RD:    n_state = rpms_pkg::S_WL_WT;
            rpms_pkg::S_WL_WT:    n_state = rpms_pkg::S_WL_DO;
            rpms_pkg::S_WL_DO:    n_state = i_sts.wl_last ? rpms_pkg::S_SH_RD
                                                          : rpms_pkg::S_WL_RD;
            rpms_pkg::S_SH_RD:    n_state = i_sts.sh_done ? rpms_pkg::S_OUT
                                                          : rpms_pkg::S_SH_WT;
            rpms_pkg::S_SH_WT:    n_state = rpms_pkg::S_SH_WR;
            rpms_pkg::S_SH_WR:    n_state = rpms_pkg::S_SH_RD;
            rpms_pkg::S_OUT:      n_state = rpms_pkg::S_IDLE;
            default:              n_state = rpms_pkg::S_IDLE;
        endcase
        if (r_state == rpms_pkg::S_RST_SEED && r_seed_last) n_state = rpms_pkg::S_IDLE;
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            rpms_pkg::S_CLEAR:    o_cmd.clr_step = 1'b1;
            rpms_pkg::S_IDLE: begin
                if (w_take) begin
                    if (!i_mode) o_cmd.clr_start = 1'b1;
                    else if (i_sts.count_zero) o_cmd.load_empty = 1'b1;
                    else o_cmd.mod_start = 1'b1;
                end
            end
            rpms_pkg::S_RST_INIT: o_cmd.clr_step = 1'b1;
            rpms_pkg::S_RST_SEED: begin
                o_cmd.seed = 1'b1;
                o_cmd.load_restart = r_seed_last;
            end
            rpms_pkg::S_MOD:      o_cmd.mod_step = 1'b1;
            rpms_pkg::S_RDID:     o_cmd.id_read = 1'b1;
            rpms_pkg::S_MARK:     o_cmd.mark_cur = 1'b1;
            rpms_pkg::S_NB_DO:    o_cmd.nb_do = 1'b1;
            rpms_pkg::S_WL_RD:    o_cmd.wl_read = 1'b1;
            rpms_pkg::S_WL_WT:    o_cmd.wl_read = 1'b1;
            rpms_pkg::S_WL_DO:    o_cmd.wl_do = 1'b1;
            rpms_pkg::S_SH_RD:    o_cmd.sh_read = 1'b1;
            rpms_pkg::S_SH_WT:    o_cmd.sh_read = 1'b1;
            rpms_pkg::S_SH_WR:    o_cmd.sh_write = 1'b1;
            rpms_pkg::S_OUT:      o_cmd.load_out = 1'b1;
            default:              o_cmd = '0;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) n_out_valid = 1'b0;
        if (w_load) n_out_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rpms_pkg::S_CLEAR;
            r_out_valid <= 1'b0;
            r_seed_cnt  <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (r_state == rpms_pkg::S_RST_SEED) r_seed_cnt <= r_seed_cnt + 1'b1;
            else r_seed_cnt <= '0;
        end
    end
endmodule

// File: rtl/random_prim_maze_step_top.sv
// Top level of the randomized Prim maze step block.
// After reset the block sweeps the 4096 cell marks once before it takes its first
// request. A restart request sweeps the marks again. A step request runs the
// bit-serial modulo, fetches and marks the chosen cell, does the neighbour and wall
// lookups through the single mark memory read port (read, wait and act for each
// direction), and shifts each frontier entry behind the chosen one down for the
// order-keeping removal, so its time grows with the frontier length. Requests are
// handled one at a time; the result register frees only when its result has been
// taken. The side length is latched from the configuration register at each restart.
module random_prim_maze_step_top (
    input  logic     i_clk,
    input  logic     i_rst_n,
    rpms_in_if.sink  in_ch,
    rpms_out_if.source out_ch,
    rpms_cfg_if.sink cfg_ch
);
    rpms_pkg::t_cmd    w_cmd;
    rpms_pkg::t_status w_sts;
    logic [6:0]        r_side_cfg;
    logic [31:0]       w_pick;
    logic [7:0]        r_order;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side_cfg <= 7'(rpms_pkg::MaxSide);
        end else if (cfg_ch.valid) begin
            r_side_cfg <= cfg_ch.grid_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ch.valid && in_ch.ready) begin
            r_order <= in_ch.dir_order;
        end
    end
    assign w_pick = in_ch.pick_random;

    rpms_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid(in_ch.valid), .o_in_ready(in_ch.ready), .i_mode(in_ch.mode),
        .o_out_valid(out_ch.valid), .i_out_ready(out_ch.ready),
        .o_cmd(w_cmd), .i_sts(w_sts));

    rpms_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .o_sts(w_sts),
        .i_side_cfg(r_side_cfg), .i_pick(w_pick), .i_order(r_order),
        .o_status(out_ch.status), .o_cell_x(out_ch.cell_x), .o_cell_y(out_ch.cell_y),
        .o_wall_dir(out_ch.wall_dir), .o_frontier_left(out_ch.frontier_left),
        .o_done_res(out_ch.done_res));
endmodule

// File: rtl/rpms_checker.sv
// Port-level checker for the maze step block, bound to the top level.
module rpms_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic [2:0]  wall_dir,
    input logic [12:0] frontier_left,
    input logic        done_res
);
    a_no_take_while_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> !in_ready) else $error("request taken while result pending");
    a_done_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> (done_res == (frontier_left == 13'd0)))
        else $error("done flag disagrees with frontier count");
    a_restart_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && status == rpms_pkg::StRestart |-> frontier_left == 13'd2 &&
        wall_dir == rpms_pkg::DirNone) else $error("bad restart result");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status))
        else $error("result dropped while stalled");
endmodule

bind random_prim_maze_step_top rpms_checker u_chk (
    .i_clk, .i_rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .status(out_ch.status), .wall_dir(out_ch.wall_dir),
    .frontier_left(out_ch.frontier_left), .done_res(out_ch.done_res));

// File: dv/testbench.sv
// Self-checking testbench for the randomized Prim maze step block.
module testbench;

    localparam logic ModeRestart = 1'b0;
    localparam logic ModeStep    = 1'b1;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  cell_x;
        logic [5:0]  cell_y;
        logic [2:0]  wall_dir;
        logic [12:0] frontier_left;
        logic        done_res;
    } t_maze_res;

    // Keeps its own copy of the maze state and the queue of predicted results.
    class maze_scoreboard;
        logic [1:0]   marks [rpms_pkg::CellTotal];
        int unsigned  frontier [$];
        logic [6:0]   side_reg;
        int unsigned  side_now;
        t_maze_res    predicted [$];
        int           errors;

        function new();
            foreach (marks[i]) marks[i] = rpms_pkg::MarkFree;
            side_reg = 7'd64;
            side_now = rpms_pkg::MaxSide;
            errors   = 0;
        endfunction

        function void note_side(logic [6:0] s);
            side_reg = s;
        endfunction

        function void add_front(int unsigned x, int unsigned y);
            int unsigned id;
            id = x + y * rpms_pkg::MaxSide;
            if (marks[id] != rpms_pkg::MarkFree) return;
            marks[id] = rpms_pkg::MarkFront;
            frontier = {frontier, id};
        endfunction

        function bit maze_at(int unsigned x, int unsigned y, logic [1:0] d);
            case (d)
                rpms_pkg::DirRight[1:0]: begin
                    if (x + 1 >= side_now) return 0;
                    return marks[(x + 1) + y * rpms_pkg::MaxSide] == rpms_pkg::MarkMaze;
                end
                rpms_pkg::DirLeft[1:0]: begin
                    if (x == 0) return 0;
                    return marks[(x - 1) + y * rpms_pkg::MaxSide] == rpms_pkg::MarkMaze;
                end
                rpms_pkg::DirDown[1:0]: begin
                    if (y + 1 >= side_now) return 0;
                    return marks[x + (y + 1) * rpms_pkg::MaxSide] == rpms_pkg::MarkMaze;
                end
                default: begin
                    if (y == 0) return 0;
                    return marks[x + (y - 1) * rpms_pkg::MaxSide] == rpms_pkg::MarkMaze;
                end
            endcase
        endfunction

        function void note_request(logic mode, logic [31:0] pick, logic [7:0] order);
            t_maze_res r;
            int unsigned idx, id, x, y;
            r = '{status: rpms_pkg::StEmpty, cell_x: 6'd0, cell_y: 6'd0,
                  wall_dir: rpms_pkg::DirNone, frontier_left: 13'd0, done_res: 1'b0};
            if (mode == ModeRestart) begin
                side_now = side_reg < 2 ? 2 :
                           (side_reg > rpms_pkg::MaxSide ? rpms_pkg::MaxSide : side_reg);
                foreach (marks[i]) marks[i] = rpms_pkg::MarkFree;
                frontier.delete();
                marks[0] = rpms_pkg::MarkMaze;
                add_front(1, 0);
                add_front(0, 1);
                r.status = rpms_pkg::StRestart;
            end else if (frontier.size() != 0) begin
                idx = pick % frontier.size();
                id  = frontier[idx];
                x   = id % rpms_pkg::MaxSide;
                y   = id / rpms_pkg::MaxSide;
                marks[id] = rpms_pkg::MarkMaze;
                if (x + 1 < side_now) add_front(x + 1, y);
                if (x != 0) add_front(x - 1, y);
                if (y + 1 < side_now) add_front(x, y + 1);
                if (y != 0) add_front(x, y - 1);
                for (int i = 0; i < 4; i++) begin
                    if (maze_at(x, y, order[2*i +: 2])) begin
                        r.wall_dir = {1'b0, order[2*i +: 2]};
                        break;
                    end
                end
                frontier.delete(idx);
                r.status = rpms_pkg::StAdded;
                r.cell_x = 6'(x);
                r.cell_y = 6'(y);
            end
            r.frontier_left = 13'(frontier.size());
            r.done_res = frontier.size() == 0;
            predicted = {predicted, r};
        endfunction

        function void check_result(t_maze_res got);
            t_maze_res exp_r;
            if (predicted.size() == 0) begin
                $display("%0t: result with nothing predicted: %p", $time, got);
                errors++;
                return;
            end
            exp_r = predicted.pop_front();
            if (got.status != exp_r.status) begin
                $display("%0t: status expected %0d actual %0d", $time, exp_r.status,
                         got.status);
                errors++;
            end
            if (got.cell_x != exp_r.cell_x) begin
                $display("%0t: cell_x expected %0d actual %0d", $time, exp_r.cell_x,
                         got.cell_x);
                errors++;
            end
            if (got.cell_y != exp_r.cell_y) begin
                $display("%0t: cell_y expected %0d actual %0d", $time, exp_r.cell_y,
                         got.cell_y);
                errors++;
            end
            if (got.wall_dir != exp_r.wall_dir) begin
                $display("%0t: wall_dir expected %0d actual %0d", $time, exp_r.wall_dir,
                         got.wall_dir);
                errors++;
            end
            if (got.frontier_left != exp_r.frontier_left) begin
                $display("%0t: frontier_left expected %0d actual %0d", $time,
                         exp_r.frontier_left, got.frontier_left);
                errors++;
            end
            if (got.done_res != exp_r.done_res) begin
                $display("%0t: done_res expected %0d actual %0d", $time, exp_r.done_res,
                         got.done_res);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    rpms_in_if  in_ch ();
    rpms_out_if out_ch ();
    rpms_cfg_if cfg_ch ();

    random_prim_maze_step_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch.sink),
        .out_ch  (out_ch.source),
        .cfg_ch  (cfg_ch.sink)
    );

    maze_scoreboard maze_sb = new();
    int  sent_count = 0;
    bit  no_gaps    = 0;
    bit  long_hold  = 0;

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // Monitor: sampled at the rising edge, before the block's updates land.
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready)
            maze_sb.note_request(in_ch.mode, in_ch.pick_random, in_ch.dir_order);
        if (i_rst_n && out_ch.valid && out_ch.ready)
            maze_sb.check_result('{out_ch.status, out_ch.cell_x, out_ch.cell_y,
                                   out_ch.wall_dir, out_ch.frontier_left,
                                   out_ch.done_res});
    end

    task automatic send_request(logic mode, logic [31:0] pick, logic [7:0] order);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid       = 1'b1;
        in_ch.mode        = mode;
        in_ch.pick_random = pick;
        in_ch.dir_order   = order;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
        sent_count++;
    endtask

    task automatic write_side(logic [6:0] s);
        in_ch.valid      = 1'b0;
        cfg_ch.valid     = 1'b1;
        cfg_ch.grid_side = s;
        do @(posedge i_clk); while (!cfg_ch.ready);
        maze_sb.note_side(s);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic drain();
        in_ch.valid = 1'b0;
        while (maze_sb.predicted.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    function automatic logic [31:0] draw_pick();
        return $urandom_range(0, 1) ? $urandom() : 32'($urandom_range(0, 15));
    endfunction

    function automatic logic [7:0] draw_order();
        return 8'($urandom_range(0, 255));
    endfunction

    // Result side: random stalls, and one long hold-off when asked for.
    initial begin
        int gap;
        out_ch.ready = 1'b0;
        @(negedge i_clk);
        forever begin
            if (long_hold) begin
                out_ch.ready = 1'b0;
                repeat (400) @(negedge i_clk);
                long_hold = 0;
            end
            gap = no_gaps ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                out_ch.ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            out_ch.ready = 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            @(negedge i_clk);
        end
    end

    initial begin
        int side, steps, phase;
        logic [6:0] s;
        in_ch.valid       = 1'b0;
        in_ch.mode        = ModeStep;
        in_ch.pick_random = '0;
        in_ch.dir_order   = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.grid_side  = 7'd64;
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Steps before any restart find an empty frontier.
        send_request(ModeStep, 32'hFFFF_FFFF, 8'hFF);
        send_request(ModeStep, 32'h0, 8'h00);
        drain();
        // A side below the minimum is used as two: the whole maze, then empty.
        write_side(7'd0);
        send_request(ModeRestart, 32'hFFFF_FFFF, 8'hFF);
        send_request(ModeStep, 32'h0, 8'hE4);
        send_request(ModeStep, 32'hFFFF_FFFF, 8'h1B);
        send_request(ModeStep, 32'h8000_0001, 8'h4E);
        send_request(ModeStep, 32'h1, 8'hB1);
        drain();
        // Above the maximum it is used as the maximum; repeated directions give no wall.
        write_side(7'd127);
        send_request(ModeRestart, 32'h0, 8'h00);
        send_request(ModeStep, 32'h0, 8'h00);
        send_request(ModeStep, 32'h7FFF_FFFE, 8'h55);
        send_request(ModeStep, 32'hFFFF_FFFF, 8'hAA);
        send_request(ModeStep, 32'h2, 8'hFF);
        drain();
        // A side written mid-generation waits for the next restart.
        write_side(7'd1);
        send_request(ModeStep, 32'h3, 8'hD8);
        send_request(ModeStep, 32'h5, 8'h27);
        send_request(ModeRestart, 32'h0, 8'h00);
        send_request(ModeStep, 32'h0, 8'hE4);
        drain();

        phase = 0;
        while (sent_count < 900) begin
            no_gaps = $urandom_range(0, 3) == 0;
            case ($urandom_range(0, 9))
                0: s = $urandom_range(0, 1) ? 7'd64 : 7'd127;
                1: s = 7'($urandom_range(0, 1));
                2: s = 7'($urandom_range(9, 20));
                3: s = 7'($urandom_range(21, 127));
                default: s = 7'($urandom_range(2, 8));
            endcase
            write_side(s);
            if (phase == 3) long_hold = 1;
            // Now and then keep the current maze and only change the pending side.
            if (phase == 0 || $urandom_range(0, 9) != 0)
                send_request(ModeRestart, $urandom(), draw_order());
            side  = s < 2 ? 2 : (s > rpms_pkg::MaxSide ? rpms_pkg::MaxSide : s);
            steps = side <= 20 ? side * side + 1 : $urandom_range(20, 60);
            for (int k = 0; k < steps; k++) begin
                if ($urandom_range(0, 49) == 0)
                    send_request(ModeRestart, $urandom(), draw_order());
                else
                    send_request(ModeStep, draw_pick(), draw_order());
            end
            drain();
            phase++;
        end

        no_gaps = 0;
        repeat (100) @(negedge i_clk);
        if (maze_sb.errors == 0 && maze_sb.predicted.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("testbench: FAIL");
        $finish;
    end
endmodule
